// ===== sv/s2c_pkg.sv =====
`timescale 1ns / 1ps

package s2c_pkg;

    // Side-band that rides along the era divider
    typedef struct packed {
        logic       neg;      // dividend was negative, quotient/remainder need flooring fix
        logic [6:0] sub_sec;  // seconds below the 128-second unit
    } s2c_side_t;

    // One converted timestamp
    typedef struct packed {
        logic [23:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
    } s2c_dt_t;

    // Time is handled in 128-second units: one day = 675 units
    localparam logic [9:0]  DAY_SUBS   = 10'd675;
    // One 400-year era in 128-second units (146097 * 675)
    localparam logic [26:0] ERA_SUBS   = 27'd98615475;
    // Shift of the epoch to 0000-03-01 in 128-second units (719468 * 675)
    localparam logic [29:0] EPOCH_SUBS = 30'd485640900;

    localparam logic [23:0] ERA_YEARS  = 24'd400;
    localparam logic [16:0] HOUR_SECS  = 17'd3600;
    localparam logic [11:0] MIN_SECS   = 12'd60;
    localparam logic [17:0] YEAR_DAYS  = 18'd365;
    localparam logic [17:0] WEEK_DAYS  = 18'd7;
    // Day of era 0 is a Wednesday; (doe + 3) mod 7 gives 0 = Sunday
    localparam logic [17:0] WD_OFFSET  = 18'd3;

    // Century boundaries inside an era (day of era)
    localparam logic [17:0] CENT1 = 18'd36524;
    localparam logic [17:0] CENT2 = 18'd73048;
    localparam logic [17:0] CENT3 = 18'd109572;

    // March-based month index of January
    localparam logic [3:0] MP_JAN = 4'd10;

    // Reciprocals for exact division by constants: q = (x * RECIP) >> shift
    localparam logic [27:0] DOE_RECIP  = 28'((64'd1 << 37) / 64'd675 + 64'd1);
    localparam logic [13:0] HOUR_RECIP = 14'((64'd1 << 21) / 64'd225 + 64'd1);
    localparam logic [10:0] MIN_RECIP  = 11'((64'd1 << 14) / 64'd15 + 64'd1);
    localparam logic [16:0] Q4Y_RECIP  = 17'((64'd1 << 25) / 64'd365 + 64'd1);
    localparam logic [18:0] YEAR_RECIP = 19'((64'd1 << 27) / 64'd365 + 64'd1);
    localparam logic [7:0]  CENT_RECIP = 8'((64'd1 << 12) / 64'd25 + 64'd1);
    localparam logic [11:0] MP_RECIP   = 12'((64'd1 << 19) / 64'd153 + 64'd1);
    localparam logic [18:0] WD_RECIP   = 19'((64'd1 << 21) / 64'd7 + 64'd1);

    // First day of year (March based) for each month index
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/s2c_era_div.sv =====
`timescale 1ns / 1ps

// Restoring divider by the era length, one quotient bit per pipeline stage
module s2c_era_div #(
    parameter int QW = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  s2c_pkg::s2c_side_t  in_side,
    input  logic [26:0]         in_rem,
    input  logic [QW-1:0]       in_dq,
    output logic                out_vld,
    output s2c_pkg::s2c_side_t  out_side,
    output logic [QW-1:0]       quot,
    output logic [26:0]         rem
);

    logic [26:0]        rem_reg  [QW];
    logic [QW-1:0]      dq_reg   [QW];
    s2c_pkg::s2c_side_t side_reg [QW];
    logic [QW-1:0]      vld_reg;

    logic [26:0]        rem_cur  [QW];
    logic [QW-1:0]      dq_cur   [QW];
    logic [27:0]        trial    [QW];
    logic               take     [QW];
    logic [26:0]        rem_next [QW];
    logic [QW-1:0]      dq_next  [QW];

    // Stage inputs: module inputs for the first stage, previous stage otherwise
    always_comb
    begin
        rem_cur[0] = in_rem;
        dq_cur[0]  = in_dq;
        for (int i = 1; i < QW; i++)
        begin
            rem_cur[i] = rem_reg[i-1];
            dq_cur[i]  = dq_reg[i-1];
        end
    end

    // One trial subtract per stage; dq shifts dividend bits out, quotient bits in
    always_comb
    begin
        for (int i = 0; i < QW; i++)
        begin
            trial[i]    = {rem_cur[i], dq_cur[i][QW-1]};
            take[i]     = trial[i] >= {1'b0, s2c_pkg::ERA_SUBS};
            rem_next[i] = take[i] ? 27'(trial[i] - {1'b0, s2c_pkg::ERA_SUBS})
                                  : trial[i][26:0];
            dq_next[i]  = {dq_cur[i][QW-2:0], take[i]};
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[QW-2:0], in_vld};
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int i = 1; i < QW; i++)
            side_reg[i] <= side_reg[i-1];
        for (int i = 0; i < QW; i++)
        begin
            rem_reg[i] <= rem_next[i];
            dq_reg[i]  <= dq_next[i];
        end
    end

    assign out_vld  = vld_reg[QW-1];
    assign out_side = side_reg[QW-1];
    assign quot     = dq_reg[QW-1];
    assign rem      = rem_reg[QW-1];

endmodule

// ===== sv/s2c_date.sv =====
`timescale 1ns / 1ps

// Era quotient and remainder to civil date, time of day and weekday (9 stages)
module s2c_date #(
    parameter int QW = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                div_vld,
    input  s2c_pkg::s2c_side_t  div_side,
    input  logic [QW-1:0]       quot,
    input  logic [26:0]         rem,
    output logic                res_vld,
    output s2c_pkg::s2c_dt_t    res
);

    logic [8:0] vld_reg;

    // Stage 1: floor fix for negative dividends
    logic signed [QW:0] era_s;
    logic [23:0] p1_era_reg;
    logic [26:0] p1_r_reg;
    logic [6:0]  p1_sub_reg;

    // Stage 2: day of era
    logic [54:0] doe_prod;
    logic [17:0] p2_doe_reg;
    logic [26:0] p2_r_reg;
    logic [6:0]  p2_sub_reg;
    logic [23:0] p2_y400_reg;

    // Stage 3: second of day, leap corrections, weekday quotient
    logic [26:0] doe_subs;
    logic [26:0] sod_hi;
    logic [32:0] q4y_prod;
    logic [17:0] wd_x3;
    logic [36:0] wd_prod;
    logic [1:0]  cent_n;
    logic [16:0] p3_sod_reg;
    logic [17:0] p3_doe_reg;
    logic [6:0]  p3_q4y_reg;
    logic [1:0]  p3_cent_reg;
    logic [14:0] p3_wq_reg;
    logic [23:0] p3_y400_reg;

    // Stage 4: hour, year-of-era numerator, weekday
    logic [26:0] hr_prod;
    logic [17:0] wd_x4;
    logic [17:0] wd_diff;
    logic [4:0]  p4_hour_reg;
    logic [16:0] p4_sod_reg;
    logic [17:0] p4_t_reg;
    logic [17:0] p4_doe_reg;
    logic [2:0]  p4_wd_reg;
    logic [23:0] p4_y400_reg;

    // Stage 5: seconds within the hour, year of era
    logic [16:0] remh_w;
    logic [36:0] yoe_prod;
    logic [11:0] p5_remh_reg;
    logic [8:0]  p5_yoe_reg;
    logic [17:0] p5_doe_reg;
    logic [4:0]  p5_hour_reg;
    logic [2:0]  p5_wd_reg;
    logic [23:0] p5_y400_reg;

    // Stage 6: minute, year-of-era terms
    logic [20:0] min_prod;
    logic [14:0] cen_prod;
    logic [5:0]  p6_min_reg;
    logic [1:0]  p6_y100_reg;
    logic [17:0] p6_y365_reg;
    logic [11:0] p6_remh_reg;
    logic [8:0]  p6_yoe_reg;
    logic [17:0] p6_doe_reg;
    logic [4:0]  p6_hour_reg;
    logic [2:0]  p6_wd_reg;
    logic [23:0] p6_y400_reg;

    // Stage 7: second, day of year
    logic [11:0] sec_w;
    logic [17:0] doy_w;
    logic [5:0]  p7_sec_reg;
    logic [8:0]  p7_doy_reg;
    logic [8:0]  p7_yoe_reg;
    logic [4:0]  p7_hour_reg;
    logic [5:0]  p7_min_reg;
    logic [2:0]  p7_wd_reg;
    logic [23:0] p7_y400_reg;

    // Stage 8: March-based month
    logic [10:0] mp_x;
    logic [22:0] mp_prod;
    logic [3:0]  p8_mp_reg;
    logic [8:0]  p8_doy_reg;
    logic [23:0] p8_ybase_reg;
    logic [4:0]  p8_hour_reg;
    logic [5:0]  p8_min_reg;
    logic [5:0]  p8_sec_reg;
    logic [2:0]  p8_wd_reg;

    // Stage 9: output
    logic [8:0]        mday_w;
    s2c_pkg::s2c_dt_t  res_next;
    s2c_pkg::s2c_dt_t  res_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[7:0], div_vld};
    end

    // Stage 1
    assign era_s = {div_side.neg, quot ^ {QW{div_side.neg}}};

    always_ff @(posedge clk)
    begin
        p1_era_reg <= 24'(era_s);
        p1_r_reg   <= div_side.neg ? (s2c_pkg::ERA_SUBS - 27'd1 - rem) : rem;
        p1_sub_reg <= div_side.sub_sec;
    end

    // Stage 2
    assign doe_prod = 55'(p1_r_reg) * 55'(s2c_pkg::DOE_RECIP);

    always_ff @(posedge clk)
    begin
        p2_doe_reg  <= doe_prod[37 +: 18];
        p2_r_reg    <= p1_r_reg;
        p2_sub_reg  <= p1_sub_reg;
        p2_y400_reg <= p1_era_reg * s2c_pkg::ERA_YEARS;
    end

    // Stage 3
    assign doe_subs = 27'(p2_doe_reg) * 27'(s2c_pkg::DAY_SUBS);
    assign sod_hi   = p2_r_reg - doe_subs;
    assign q4y_prod = 33'(p2_doe_reg[17:2]) * 33'(s2c_pkg::Q4Y_RECIP);
    assign wd_x3    = p2_doe_reg + s2c_pkg::WD_OFFSET;
    assign wd_prod  = 37'(wd_x3) * 37'(s2c_pkg::WD_RECIP);
    // Centuries passed in the era, with the last day of the era kept in century 3
    assign cent_n   = 2'(p2_doe_reg >= s2c_pkg::CENT1) + 2'(p2_doe_reg >= s2c_pkg::CENT2)
                    + 2'(p2_doe_reg >= s2c_pkg::CENT3);

    always_ff @(posedge clk)
    begin
        p3_sod_reg  <= {sod_hi[9:0], p2_sub_reg};
        p3_doe_reg  <= p2_doe_reg;
        p3_q4y_reg  <= q4y_prod[25 +: 7];
        p3_cent_reg <= cent_n;
        p3_wq_reg   <= wd_prod[21 +: 15];
        p3_y400_reg <= p2_y400_reg;
    end

    // Stage 4
    assign hr_prod = 27'(p3_sod_reg[16:4]) * 27'(s2c_pkg::HOUR_RECIP);
    assign wd_x4   = p3_doe_reg + s2c_pkg::WD_OFFSET;
    assign wd_diff = wd_x4 - 18'(p3_wq_reg) * s2c_pkg::WEEK_DAYS;

    always_ff @(posedge clk)
    begin
        p4_hour_reg <= hr_prod[21 +: 5];
        p4_sod_reg  <= p3_sod_reg;
        p4_t_reg    <= p3_doe_reg - 18'(p3_q4y_reg) + 18'(p3_cent_reg);
        p4_doe_reg  <= p3_doe_reg;
        p4_wd_reg   <= wd_diff[2:0];
        p4_y400_reg <= p3_y400_reg;
    end

    // Stage 5
    assign remh_w   = p4_sod_reg - 17'(p4_hour_reg) * s2c_pkg::HOUR_SECS;
    assign yoe_prod = 37'(p4_t_reg) * 37'(s2c_pkg::YEAR_RECIP);

    always_ff @(posedge clk)
    begin
        p5_remh_reg <= remh_w[11:0];
        p5_yoe_reg  <= yoe_prod[27 +: 9];
        p5_doe_reg  <= p4_doe_reg;
        p5_hour_reg <= p4_hour_reg;
        p5_wd_reg   <= p4_wd_reg;
        p5_y400_reg <= p4_y400_reg;
    end

    // Stage 6
    assign min_prod = 21'(p5_remh_reg[11:2]) * 21'(s2c_pkg::MIN_RECIP);
    assign cen_prod = 15'(p5_yoe_reg[8:2]) * 15'(s2c_pkg::CENT_RECIP);

    always_ff @(posedge clk)
    begin
        p6_min_reg  <= min_prod[14 +: 6];
        p6_y100_reg <= cen_prod[12 +: 2];
        p6_y365_reg <= 18'(p5_yoe_reg) * s2c_pkg::YEAR_DAYS;
        p6_remh_reg <= p5_remh_reg;
        p6_yoe_reg  <= p5_yoe_reg;
        p6_doe_reg  <= p5_doe_reg;
        p6_hour_reg <= p5_hour_reg;
        p6_wd_reg   <= p5_wd_reg;
        p6_y400_reg <= p5_y400_reg;
    end

    // Stage 7
    assign sec_w = p6_remh_reg - 12'(p6_min_reg) * s2c_pkg::MIN_SECS;
    assign doy_w = p6_doe_reg
                 - (p6_y365_reg + 18'(p6_yoe_reg[8:2]) - 18'(p6_y100_reg));

    always_ff @(posedge clk)
    begin
        p7_sec_reg  <= sec_w[5:0];
        p7_doy_reg  <= doy_w[8:0];
        p7_yoe_reg  <= p6_yoe_reg;
        p7_hour_reg <= p6_hour_reg;
        p7_min_reg  <= p6_min_reg;
        p7_wd_reg   <= p6_wd_reg;
        p7_y400_reg <= p6_y400_reg;
    end

    // Stage 8: mp = (5 * doy + 2) / 153
    assign mp_x    = {p7_doy_reg, 2'b00} + 11'(p7_doy_reg) + 11'd2;
    assign mp_prod = 23'(mp_x) * 23'(s2c_pkg::MP_RECIP);

    always_ff @(posedge clk)
    begin
        p8_mp_reg    <= mp_prod[19 +: 4];
        p8_doy_reg   <= p7_doy_reg;
        p8_ybase_reg <= p7_y400_reg + 24'(p7_yoe_reg);
        p8_hour_reg  <= p7_hour_reg;
        p8_min_reg   <= p7_min_reg;
        p8_sec_reg   <= p7_sec_reg;
        p8_wd_reg    <= p7_wd_reg;
    end

    // Stage 9: month, day, and year bump for January and February
    assign mday_w = p8_doy_reg - s2c_pkg::month_start(p8_mp_reg) + 9'd1;

    always_comb
    begin
        res_next.year   = p8_ybase_reg + 24'(p8_mp_reg >= s2c_pkg::MP_JAN);
        res_next.month  = (p8_mp_reg < s2c_pkg::MP_JAN) ? (p8_mp_reg + 4'd3)
                                                         : (p8_mp_reg - 4'd9);
        res_next.mday   = mday_w[4:0];
        res_next.hour   = p8_hour_reg;
        res_next.minute = p8_min_reg;
        res_next.second = p8_sec_reg;
        res_next.wday   = p8_wd_reg;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_vld = vld_reg[8];
    assign res     = res_reg;

endmodule

// ===== sv/seconds_to_civil_datetime.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Signals                                   Transfer
// input    in   start, busy, epoch_seconds                start && !busy at clk rise
// result   out  done, year, month, day_of_month, hour,    done high for one cycle
//               minute, second, weekday
//
// One transfer per cycle in, one result per cycle out, in order.
// Pipeline: an input stage, the era divider with one quotient bit per stage, and
// nine date stages.
// rst_n clears all valid bits at once; items in flight are dropped.
// busy is always low and the pipeline never holds: results cannot be stalled.
module seconds_to_civil_datetime #(
    parameter int SECONDS_WIDTH = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [SECONDS_WIDTH-1:0] epoch_seconds,
    output logic                            done,
    output logic signed [23:0]              year,
    output logic        [3:0]               month,
    output logic        [4:0]               day_of_month,
    output logic        [4:0]               hour,
    output logic        [5:0]               minute,
    output logic        [5:0]               second,
    output logic        [2:0]               weekday
);

    localparam int SH_W = SECONDS_WIDTH - 7;
    localparam int OFS_W = $bits(s2c_pkg::EPOCH_SUBS);
    localparam int AW = ((SH_W > OFS_W) ? SH_W : OFS_W) + 1;
    localparam int BW = AW - 1;
    localparam int QW = BW - ($bits(s2c_pkg::ERA_SUBS) - 1);
    localparam int LAT = QW + 10;

    logic [AW-1:0]       epoch_adj;
    logic                in_vld_reg;
    logic [BW-1:0]       in_b_reg;
    s2c_pkg::s2c_side_t  in_side_reg;

    logic                div_vld;
    s2c_pkg::s2c_side_t  div_side;
    logic [QW-1:0]       div_quot;
    logic [26:0]         div_rem;

    logic                res_vld;
    s2c_pkg::s2c_dt_t    res;

    assign busy = 1'b0;

    // Time in 128-second units, moved to the 0000-03-01 epoch
    assign epoch_adj = AW'($signed(epoch_seconds[SECONDS_WIDTH-1:7]))
                     + AW'(s2c_pkg::EPOCH_SUBS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    // Negative values are complemented; the date stages undo it for a floored result
    always_ff @(posedge clk)
    begin
        in_b_reg            <= epoch_adj[BW-1:0] ^ {BW{epoch_adj[AW-1]}};
        in_side_reg.neg     <= epoch_adj[AW-1];
        in_side_reg.sub_sec <= epoch_seconds[6:0];
    end

    s2c_era_div #(
        .QW (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_vld_reg),
        .in_side  (in_side_reg),
        .in_rem   ({1'b0, in_b_reg[BW-1:QW]}),
        .in_dq    (in_b_reg[QW-1:0]),
        .out_vld  (div_vld),
        .out_side (div_side),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    s2c_date #(
        .QW (QW)
    ) u_date (
        .clk      (clk),
        .rst_n    (rst_n),
        .div_vld  (div_vld),
        .div_side (div_side),
        .quot     (div_quot),
        .rem      (div_rem),
        .res_vld  (res_vld),
        .res      (res)
    );

    assign done         = res_vld;
    assign year         = res.year;
    assign month        = res.month;
    assign day_of_month = res.mday;
    assign hour         = res.hour;
    assign minute       = res.minute;
    assign second       = res.second;
    assign weekday      = res.wday;

    // Every accepted item comes out as a result on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after fixed latency");

    // No result without an accepted item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching input");

    // Result fields within their calendar ranges
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month >= 4'd1) && (month <= 4'd12) && (day_of_month >= 5'd1)
                 && (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59)
                 && (weekday <= 3'd6))
        else $error("result field out of range");

endmodule

// ===== tb/tb_seconds_to_civil_datetime.sv =====
`timescale 1ns / 1ps

module tb_seconds_to_civil_datetime;

    import s2c_pkg::*;

    localparam int      SECS_W        = 48;
    localparam longint  SECS_IN_DAY   = 86400;
    localparam longint  MARCH0_SHIFT  = 719468;
    localparam longint  ERA_DAYS      = 146097;
    localparam longint  SECS_MAX      = 64'sd140737488355327;
    localparam longint  SECS_MIN      = -64'sd140737488355328;
    localparam int      STALL_LIMIT   = 2000;
    localparam int      DRAIN_CYCLES  = 30;
    localparam int      PHASE_ITEMS   = 300;

    // Days of era that sit on leap, century and era edges
    localparam int ERA_EDGES [22] = '{0, 1, 59, 60, 305, 306, 364, 365, 1459, 1460, 1461,
                                      36523, 36524, 36525, 73047, 73048, 73049,
                                      109571, 109572, 109573, 146095, 146096};

    // Directed timestamps: epoch, time-of-day edges, leap days, centuries, extremes
    localparam longint DIRECTED [24] = '{
        0, -1, 1, 59, 60, 3599, 3600, 86399, 86400, -86400, -86401,
        951782400, 951868799, -2208988800, -2203891201, -2203891200,
        4107542399, 4107542400, -62167219200, -62162121600, 253402300799,
        SECS_MAX, SECS_MIN, 64'sh0000_AAAA_AAAA_AAAA
    };

    // Expected civil dates, checked in order of arrival
    class datetime_scoreboard;
        s2c_dt_t     pending_dates[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // Floored split into days and time of day, then March-based era conversion
        static function s2c_dt_t civil_from_seconds(logic [SECS_W-1:0] raw);
            longint  total, day_num, sec_of_day, week_pos, shifted, era_idx;
            longint  day_in_era, year_in_era, day_in_year, mar_month, mday, mon, yr;
            s2c_dt_t r;
            total      = longint'($signed(raw));
            day_num    = total / SECS_IN_DAY;
            sec_of_day = total % SECS_IN_DAY;
            if (sec_of_day < 0)
            begin
                sec_of_day += SECS_IN_DAY;
                day_num    -= 1;
            end
            week_pos = day_num % 7;
            if (week_pos < 0)
                week_pos += 7;
            week_pos    = (week_pos + 4) % 7;
            shifted     = day_num + MARCH0_SHIFT;
            era_idx     = (shifted >= 0 ? shifted : shifted - (ERA_DAYS - 1)) / ERA_DAYS;
            day_in_era  = shifted - era_idx * ERA_DAYS;
            year_in_era = (day_in_era - day_in_era / 1460 + day_in_era / 36524
                           - day_in_era / 146096) / 365;
            day_in_year = day_in_era - (365 * year_in_era + year_in_era / 4
                           - year_in_era / 100);
            mar_month   = (5 * day_in_year + 2) / 153;
            mday        = day_in_year - (153 * mar_month + 2) / 5 + 1;
            mon         = (mar_month < 10) ? mar_month + 3 : mar_month - 9;
            yr          = year_in_era + era_idx * 400 + ((mon <= 2) ? 1 : 0);
            r.year   = yr[23:0];
            r.month  = mon[3:0];
            r.mday   = mday[4:0];
            r.hour   = 5'(sec_of_day / 3600);
            r.minute = 6'((sec_of_day % 3600) / 60);
            r.second = 6'(sec_of_day % 60);
            r.wday   = week_pos[2:0];
            return r;
        endfunction

        function void note_timestamp(logic [SECS_W-1:0] raw);
            pending_dates.push_back(civil_from_seconds(raw));
        endfunction

        function void check_datetime(s2c_dt_t got);
            s2c_dt_t want;
            if (pending_dates.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with no pending timestamp: %0d-%0d-%0d", $realtime,
                             $signed(got.year), got.month, got.mday);
                return;
            end
            want = pending_dates.pop_front();
            if (want.year != got.year || want.month != got.month || want.mday != got.mday ||
                want.hour != got.hour || want.minute != got.minute ||
                want.second != got.second || want.wday != got.wday)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: expected %0d-%0d-%0d %0d:%0d:%0d wd%0d, got %0d-%0d-%0d %0d:%0d:%0d wd%0d",
                             $realtime, $signed(want.year), want.month, want.mday,
                             want.hour, want.minute, want.second, want.wday,
                             $signed(got.year), got.month, got.mday,
                             got.hour, got.minute, got.second, got.wday);
            end
        endfunction

        function int outstanding();
            return pending_dates.size();
        endfunction

        function bit clean();
            return errors == 0 && pending_dates.size() == 0;
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [SECS_W-1:0] epoch_seconds;
    logic              done;
    logic [23:0]       year;
    logic [3:0]        month;
    logic [4:0]        day_of_month;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [2:0]        weekday;

    datetime_scoreboard dates = new();
    int                 idle_pct;
    int                 quiet_cycles;

    seconds_to_civil_datetime #(
        .SECONDS_WIDTH(SECS_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .epoch_seconds(epoch_seconds),
        .done         (done),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second),
        .weekday      (weekday)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: input transfers and result strobes, both at the rising edge
    always @(posedge clk)
    begin : monitor
        s2c_dt_t got;
        if (rst_n)
        begin
            if (start && !busy)
                dates.note_timestamp(epoch_seconds);
            if (done)
            begin
                got.year   = year;
                got.month  = month;
                got.mday   = day_of_month;
                got.hour   = hour;
                got.minute = minute;
                got.second = second;
                got.wday   = weekday;
                dates.check_datetime(got);
            end
        end
    end

    // Watchdog: no transfer in either direction for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_timestamp(input logic [SECS_W-1:0] secs);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start         <= 1'b1;
        epoch_seconds <= secs;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Drop start and wait until every pending date has come back
    task automatic drain_dates();
        start <= 1'b0;
        while (dates.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mix of raw bit patterns, calendar edges, present day and range extremes
    function automatic logic [SECS_W-1:0] random_timestamp();
        longint t;
        longint era_idx;
        longint day_num;
        longint doe;
        int     kind;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
            t = longint'({$urandom, $urandom});
        else if (kind <= 6)
        begin
            era_idx = longint'($urandom_range(0, 22000)) - 11000;
            if ($urandom_range(0, 3) == 0)
                doe = longint'($urandom_range(0, 146096));
            else
                doe = ERA_EDGES[$urandom_range(0, 21)];
            day_num = era_idx * ERA_DAYS + doe - MARCH0_SHIFT;
            case ($urandom_range(0, 2))
                0:       t = day_num * SECS_IN_DAY;
                1:       t = day_num * SECS_IN_DAY + SECS_IN_DAY - 1;
                default: t = day_num * SECS_IN_DAY + longint'($urandom_range(0, 86399));
            endcase
        end
        else if (kind == 7)
            t = longint'($urandom) * 2 - 64'sd4000000000;
        else if (kind == 8)
            t = $urandom_range(0, 1) ? SECS_MAX - longint'($urandom_range(0, 200000))
                                     : SECS_MIN + longint'($urandom_range(0, 200000));
        else
            t = longint'($urandom_range(0, 400000)) - 200000;
        return t[SECS_W-1:0];
    endfunction

    initial
    begin : stimulus
        int phase_idle [4] = '{0, 67, 0, 26};
        rst_n         = 1'b0;
        start         = 1'b0;
        epoch_seconds = '0;
        idle_pct      = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items back to back, then the complement pattern
        foreach (DIRECTED[i])
            send_timestamp(DIRECTED[i][SECS_W-1:0]);
        send_timestamp(48'h5555_5555_5555);
        drain_dates();

        // Random phases with different sender gap rates
        foreach (phase_idle[p])
        begin
            idle_pct = phase_idle[p];
            repeat (PHASE_ITEMS)
                send_timestamp(random_timestamp());
            drain_dates();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (dates.clean())
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
